FILE: hdl/histogram_percentile_levels_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the histogram percentile levels unit
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_PERCENTILE_LEVELS_UNIT_MACROS_SVH
`define HISTOGRAM_PERCENTILE_LEVELS_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define HPL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hpl assertion failed");

// Consequent checked in the cycle after the antecedent
`define HPL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hpl assertion failed");

`endif

FILE: hdl/hpl_pkg.sv
// ----------------------------------------------------------------------------
// hpl_pkg
// Shared widths, defaults, register indexes and types of the histogram
// percentile levels unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hpl_pkg;

    // Field widths
    localparam int LVL_W   = 16;    // Q8.8 levels, floor and buckets per dB; Q4.12 dB per bucket
    localparam int PCT_W   = 10;    // per-mille values
    localparam int BINS_W  = 13;    // frame length register
    localparam int CFG_IDX_W = 3;

    // Largest frame length the length register can express
    localparam int BIN_LIMIT = 8191;

    // Default structure sizes
    localparam int DEF_BUCKETS  = 1024;
    localparam int DEF_MAX_BINS = 4096;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_PERCENTILE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_PERCENTILE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_FLOOR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BUCKETS_PER_DB = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DB_PER_BUCKET  = 3'd5;

    // Register reset values
    localparam logic [BINS_W-1:0]       RST_BIN_COUNT       = 13'd1024;
    localparam logic [PCT_W-1:0]        RST_LOW_PERCENTILE  = 10'd100;
    localparam logic [PCT_W-1:0]        RST_HIGH_PERCENTILE = 10'd900;
    localparam logic signed [LVL_W-1:0] RST_RANGE_FLOOR     = -16'sd30720;
    localparam logic [LVL_W-1:0]        RST_BUCKETS_PER_DB  = 16'd2048;
    localparam logic [LVL_W-1:0]        RST_DB_PER_BUCKET   = 16'd512;

    // Per-mille full scale
    localparam logic [PCT_W-1:0] PERMILLE_FULL = 10'd1000;

    // floor(x / 1000) = (x * RECIP_M) >> RECIP_SH, exact for x below 2^23
    localparam int RECIP_W  = 24;
    localparam int RECIP_SH = 33;
    localparam logic [RECIP_W-1:0] RECIP_M = 24'd8589935;

    // Scan sequencer status
    typedef struct packed {
        logic busy;
        logic done;
    } scan_sts_t;

endpackage

FILE: hdl/hpl_ram.sv
// ----------------------------------------------------------------------------
// hpl_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read (old data on a same-address write).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpl_ram
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/hpl_bin.sv
// ----------------------------------------------------------------------------
// hpl_bin
// Sample path: maps each sample to a bucket and increments that bucket's
// count with a read-modify-write through the histogram RAM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpl_bin
    import hpl_pkg::*;
#(
    parameter int BUCKETS = DEF_BUCKETS,
    parameter int CW      = BINS_W
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic signed [LVL_W-1:0] sample_db,
    input  logic signed [LVL_W-1:0] range_floor,
    input  logic [LVL_W-1:0]        buckets_per_db,
    output logic                    rd_en,
    output logic [$clog2(BUCKETS)-1:0] rd_addr,
    input  logic [CW-1:0]           rd_data,
    output logic                    wr_en,
    output logic [$clog2(BUCKETS)-1:0] wr_addr,
    output logic [CW-1:0]           wr_data
);

    localparam int AW    = $clog2(BUCKETS);
    localparam int DIF_W = LVL_W + 1;
    localparam int PRD_W = 2 * DIF_W;
    localparam int RAW_W = PRD_W - LVL_W - 1;
    localparam logic [RAW_W-1:0] TOP_RAW = RAW_W'(BUCKETS - 1);
    localparam logic [AW-1:0]    IDX_MASK = AW'(BUCKETS - 1);

    // Stage valids
    logic va_reg, vb_reg, vc_reg;
    // Forward of the write made in the previous cycle
    logic fwd_valid_reg;

    // Payload
    logic signed [DIF_W-1:0] diff_reg, diff_next;
    logic signed [PRD_W-1:0] prod_reg, prod_next;
    logic [AW-1:0]           addr_c_reg;
    logic [AW-1:0]           fwd_addr_reg;
    logic [CW-1:0]           fwd_data_reg;

    logic signed [DIF_W-1:0] scale_s;
    logic [RAW_W-1:0]        raw_b;
    logic [RAW_W-1:0]        clamp_b;
    logic [AW-1:0]           idx;
    logic [CW-1:0]           base_cnt;

    // Offset from the floor, then scale to Q16.16 bucket units
    always_comb
    begin
        diff_next = DIF_W'(sample_db) - DIF_W'(range_floor);
        scale_s   = $signed({1'b0, buckets_per_db});
        prod_next = PRD_W'(diff_reg) * PRD_W'(scale_s);
    end

    // Bucket index: negative goes to zero, overflow to the top bucket
    always_comb
    begin
        raw_b = prod_reg[PRD_W-2:LVL_W];
        if (prod_reg[PRD_W-1])
        begin
            clamp_b = '0;
        end
        else if (raw_b > TOP_RAW)
        begin
            clamp_b = TOP_RAW;
        end
        else
        begin
            clamp_b = raw_b;
        end
        idx = clamp_b[AW-1:0] & IDX_MASK;
    end

    assign rd_en   = vb_reg;
    assign rd_addr = idx;

    // Increment, taking the last written count when it hit the same bucket
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == addr_c_reg))
        begin
            base_cnt = fwd_data_reg;
        end
        else
        begin
            base_cnt = rd_data;
        end
    end

    assign wr_en   = vc_reg;
    assign wr_addr = addr_c_reg;
    assign wr_data = base_cnt + CW'(1);

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            vc_reg        <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            va_reg        <= accept;
            vb_reg        <= va_reg;
            vc_reg        <= vb_reg;
            fwd_valid_reg <= vc_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        diff_reg     <= diff_next;
        prod_reg     <= prod_next;
        addr_c_reg   <= idx;
        fwd_addr_reg <= addr_c_reg;
        fwd_data_reg <= wr_data;
    end

endmodule

FILE: hdl/hpl_scan.sv
// ----------------------------------------------------------------------------
// hpl_scan
// Bucket sweep: reads every bucket in order, accumulates the running
// count, finds the low and high rank buckets and writes each bucket back
// to zero. The same sweep clears the histogram after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpl_scan
    import hpl_pkg::*;
#(
    parameter int BUCKETS = DEF_BUCKETS,
    parameter int CW      = BINS_W
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [CW-1:0]              rank_lo,
    input  logic [CW-1:0]              rank_hi,
    output logic [$clog2(BUCKETS)-1:0] rd_addr,
    input  logic [CW-1:0]              rd_data,
    output logic                       wr_en,
    output logic [$clog2(BUCKETS)-1:0] wr_addr,
    output logic [CW-1:0]              wr_data,
    output logic [$clog2(BUCKETS)-1:0] lo_bucket,
    output logic [$clog2(BUCKETS)-1:0] hi_bucket,
    output scan_sts_t                  sts
);

    localparam int AW = $clog2(BUCKETS);
    localparam logic [AW-1:0] LAST_IDX = AW'(BUCKETS - 1);

    // Control
    logic issuing_reg, issuing_next;
    logic dv_reg;
    logic lo_f_reg, lo_f_next;
    logic hi_f_reg, hi_f_next;

    // Payload
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] daddr_reg;
    logic [CW-1:0] cum_reg, cum_next;
    logic [AW-1:0] lo_b_reg, lo_b_next;
    logic [AW-1:0] hi_b_reg, hi_b_next;

    logic [CW-1:0] cum_sum;

    // Read address sequencing
    always_comb
    begin
        issuing_next = issuing_reg;
        idx_next     = idx_reg;
        if (start)
        begin
            issuing_next = 1'b1;
            idx_next     = '0;
        end
        else if (issuing_reg)
        begin
            if (idx_reg == LAST_IDX)
            begin
                issuing_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + AW'(1);
            end
        end
    end

    // Running count and first-crossing search
    always_comb
    begin
        cum_sum   = cum_reg + rd_data;
        cum_next  = cum_reg;
        lo_f_next = lo_f_reg;
        hi_f_next = hi_f_reg;
        lo_b_next = lo_b_reg;
        hi_b_next = hi_b_reg;
        if (start)
        begin
            cum_next  = '0;
            lo_f_next = 1'b0;
            hi_f_next = 1'b0;
            lo_b_next = '0;
            hi_b_next = '0;
        end
        else if (dv_reg)
        begin
            cum_next = cum_sum;
            if (!lo_f_reg && (cum_sum > rank_lo))
            begin
                lo_f_next = 1'b1;
                lo_b_next = daddr_reg;
            end
            if (!hi_f_reg && (cum_sum > rank_hi))
            begin
                hi_f_next = 1'b1;
                hi_b_next = daddr_reg;
            end
        end
    end

    assign rd_addr   = idx_reg;
    assign wr_en     = dv_reg;
    assign wr_addr   = daddr_reg;
    assign wr_data   = '0;
    assign lo_bucket = lo_b_reg;
    assign hi_bucket = hi_b_reg;
    assign sts.busy  = issuing_reg | dv_reg;
    assign sts.done  = dv_reg && (daddr_reg == LAST_IDX);

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issuing_reg <= 1'b0;
            dv_reg      <= 1'b0;
            lo_f_reg    <= 1'b0;
            hi_f_reg    <= 1'b0;
        end
        else
        begin
            issuing_reg <= issuing_next;
            dv_reg      <= issuing_reg;
            lo_f_reg    <= lo_f_next;
            hi_f_reg    <= hi_f_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        daddr_reg <= idx_reg;
        cum_reg   <= cum_next;
        lo_b_reg  <= lo_b_next;
        hi_b_reg  <= hi_b_next;
    end

endmodule

FILE: hdl/histogram_percentile_levels_unit.sv
// ----------------------------------------------------------------------------
// histogram_percentile_levels_unit
// Per-frame histogram of decibel samples with low and high percentile
// level extraction.
// ----------------------------------------------------------------------------
//   s_*: one signed Q8.8 sample per transaction, one per cycle within a frame
//   of bin_count samples (0 acts as 1, above MAX_BINS acts as MAX_BINS).
//   A sample's bucket count is written back in stage vc, after va and vb.
//   m_*: one transaction per frame with the low and high bucket centres;
//   m_tuser set means low percentile not below high, both levels zero.
//   After the last sample s_tready is low while the unit drains, sweeps the
//   RAM (reading every bucket, clearing as it goes) and forms the centre
//   values; with the output register free, the result loads at the edge
//   that reopens s_tready. After reset s_tready stays low while the sweep
//   clears the bucket RAM; configuration writes are taken meanwhile.
//   A result stalled by m_tready holds while the next frame streams in; a
//   frame that ends before it is taken waits, s_tready low, until it frees.
//   Configuration: write-only port, register index per the register list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module histogram_percentile_levels_unit
    import hpl_pkg::*;
#(
    parameter int BUCKETS  = DEF_BUCKETS,
    parameter int MAX_BINS = DEF_MAX_BINS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Sample input
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [LVL_W-1:0]     s_tdata,    // [15:0] sample_db
    // Level output
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [2*LVL_W-1:0]   m_tdata,    // [15:0] low_level, [31:16] high_level
    output logic                 m_tuser,    // [0] status
    // Configuration
    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LVL_W-1:0]     cfg_wdata
);

    localparam int NMAX = (MAX_BINS < BIN_LIMIT) ? MAX_BINS : BIN_LIMIT;
    localparam int CW   = $clog2(NMAX + 1);
    localparam int AW   = $clog2(BUCKETS);
    localparam int XR_W = CW + PCT_W;
    localparam int QP_W = XR_W + RECIP_W;
    localparam int CX_W = AW + 1 + LVL_W;
    localparam int V_W  = CX_W + 2;
    localparam int CTR_SH = 5;

    localparam logic [BINS_W-1:0] NMAX_LEN = BINS_W'(NMAX);
    localparam logic [CX_W:0]     CTR_RND  = (CX_W + 1)'(16);
    localparam logic signed [V_W-1:0] SAT_HI = V_W'(32767);
    localparam logic signed [V_W-1:0] SAT_LO = V_W'(-32768);

    localparam logic [2:0] DRAIN_LAST = 3'd5;

    // Controller states
    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_CLEAR  = 3'd1;
    localparam logic [2:0] ST_RUN    = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_SCAN   = 3'd4;
    localparam logic [2:0] ST_CENTRE = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    // Configuration registers
    logic [BINS_W-1:0]       bin_count_reg;
    logic [PCT_W-1:0]        low_pct_reg;
    logic [PCT_W-1:0]        high_pct_reg;
    logic signed [LVL_W-1:0] range_floor_reg;
    logic [LVL_W-1:0]        buckets_per_db_reg;
    logic [LVL_W-1:0]        db_per_bucket_reg;

    // Control state
    logic [2:0]    state_reg, state_next;
    logic [2:0]    drain_reg, drain_next;
    logic [CW-1:0] seen_reg, seen_next;
    logic          out_valid_reg, out_valid_next;

    // Rank pipeline and result payload
    logic [CW-1:0]   n_reg;
    logic [XR_W-1:0] xr_lo_reg, xr_hi_reg;
    logic [CW-1:0]   q_lo_reg, q_hi_reg;
    logic [CW-1:0]   rank_lo_reg, rank_hi_reg;
    logic [CX_W-1:0] cx_lo_reg, cx_hi_reg;
    logic [LVL_W-1:0] low_level_reg, high_level_reg;
    logic             status_reg;

    logic            accept;
    logic            frame_end;
    logic            scan_start;
    logic            load_out;
    logic [BINS_W-1:0] n_full;
    logic [CW-1:0]   n_eff;
    logic [CW:0]     seen_plus;
    logic [PCT_W-1:0] lo_p, hi_p;
    logic            bad_pct;
    logic [QP_W-1:0] qp_lo, qp_hi;
    logic [CX_W:0]   rnd_lo, rnd_hi;
    logic signed [V_W-1:0] v_lo, v_hi;

    // RAM wiring
    logic          bin_rd_en, bin_wr_en, scan_wr_en;
    logic [AW-1:0] bin_rd_addr, bin_wr_addr, scan_rd_addr, scan_wr_addr;
    logic [CW-1:0] bin_wr_data, scan_wr_data;
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr, ram_rd_addr;
    logic [CW-1:0] ram_wr_data, ram_rd_data;
    logic [AW-1:0] lo_bucket, hi_bucket;
    scan_sts_t     scan_sts;

    function automatic logic [LVL_W-1:0] sat_level(input logic signed [V_W-1:0] v);
        logic [LVL_W-1:0] r;
        if (v > SAT_HI)
        begin
            r = SAT_HI[LVL_W-1:0];
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO[LVL_W-1:0];
        end
        else
        begin
            r = v[LVL_W-1:0];
        end
        return r;
    endfunction

    // Frame length and clamped percentiles
    always_comb
    begin
        if (bin_count_reg == '0)
        begin
            n_full = BINS_W'(1);
        end
        else if (bin_count_reg > NMAX_LEN)
        begin
            n_full = NMAX_LEN;
        end
        else
        begin
            n_full = bin_count_reg;
        end
        n_eff   = n_full[CW-1:0];
        lo_p    = (low_pct_reg > PERMILLE_FULL) ? PERMILLE_FULL : low_pct_reg;
        hi_p    = (high_pct_reg > PERMILLE_FULL) ? PERMILLE_FULL : high_pct_reg;
        bad_pct = (lo_p >= hi_p);
    end

    // Rank = floor(n * permille / 1000) by reciprocal multiply, capped at n - 1
    assign qp_lo = QP_W'(xr_lo_reg) * QP_W'(RECIP_M);
    assign qp_hi = QP_W'(xr_hi_reg) * QP_W'(RECIP_M);

    // Bucket centre: round (x / 32) half up, add floor, saturate
    always_comb
    begin
        rnd_lo = {1'b0, cx_lo_reg} + CTR_RND;
        rnd_hi = {1'b0, cx_hi_reg} + CTR_RND;
        v_lo   = V_W'($signed({1'b0, rnd_lo[CX_W:CTR_SH]})) + V_W'(range_floor_reg);
        v_hi   = V_W'($signed({1'b0, rnd_hi[CX_W:CTR_SH]})) + V_W'(range_floor_reg);
    end

    // Sequencer
    assign s_tready  = (state_reg == ST_RUN);
    assign accept    = s_tvalid && s_tready;
    assign seen_plus = {1'b0, seen_reg} + (CW + 1)'(1);
    assign frame_end = (seen_plus >= {1'b0, n_eff});
    assign load_out  = (state_reg == ST_OUT) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next     = state_reg;
        drain_next     = drain_reg;
        seen_next      = seen_reg;
        scan_start     = 1'b0;
        out_valid_next = out_valid_reg;
        if (m_tvalid && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_INIT:
            begin
                scan_start = 1'b1;
                state_next = ST_CLEAR;
            end
            ST_CLEAR:
            begin
                if (scan_sts.done)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (accept)
                begin
                    if (frame_end)
                    begin
                        seen_next  = '0;
                        drain_next = '0;
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        seen_next = seen_plus[CW-1:0];
                    end
                end
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg + 3'd1;
                if (drain_reg == DRAIN_LAST)
                begin
                    scan_start = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_sts.done)
                begin
                    state_next = ST_CENTRE;
                end
            end
            ST_CENTRE:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_INIT;
            drain_reg          <= '0;
            seen_reg           <= '0;
            out_valid_reg      <= 1'b0;
            bin_count_reg      <= RST_BIN_COUNT;
            low_pct_reg        <= RST_LOW_PERCENTILE;
            high_pct_reg       <= RST_HIGH_PERCENTILE;
            range_floor_reg    <= RST_RANGE_FLOOR;
            buckets_per_db_reg <= RST_BUCKETS_PER_DB;
            db_per_bucket_reg  <= RST_DB_PER_BUCKET;
        end
        else
        begin
            state_reg     <= state_next;
            drain_reg     <= drain_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen)
            begin
                case (cfg_index)
                    REG_BIN_COUNT:       bin_count_reg      <= cfg_wdata[BINS_W-1:0];
                    REG_LOW_PERCENTILE:  low_pct_reg        <= cfg_wdata[PCT_W-1:0];
                    REG_HIGH_PERCENTILE: high_pct_reg       <= cfg_wdata[PCT_W-1:0];
                    REG_RANGE_FLOOR:     range_floor_reg    <= cfg_wdata;
                    REG_BUCKETS_PER_DB:  buckets_per_db_reg <= cfg_wdata;
                    REG_DB_PER_BUCKET:   db_per_bucket_reg  <= cfg_wdata;
                    default:             ;
                endcase
            end
        end
    end

    // Rank pipeline, centre products and result payload
    always_ff @(posedge clk)
    begin
        n_reg       <= n_eff;
        xr_lo_reg   <= XR_W'(n_eff) * XR_W'(lo_p);
        xr_hi_reg   <= XR_W'(n_eff) * XR_W'(hi_p);
        q_lo_reg    <= qp_lo[RECIP_SH +: CW];
        q_hi_reg    <= qp_hi[RECIP_SH +: CW];
        rank_lo_reg <= (q_lo_reg > (n_reg - CW'(1))) ? (n_reg - CW'(1)) : q_lo_reg;
        rank_hi_reg <= (q_hi_reg > (n_reg - CW'(1))) ? (n_reg - CW'(1)) : q_hi_reg;
        if (state_reg == ST_CENTRE)
        begin
            cx_lo_reg <= CX_W'({lo_bucket, 1'b1}) * CX_W'(db_per_bucket_reg);
            cx_hi_reg <= CX_W'({hi_bucket, 1'b1}) * CX_W'(db_per_bucket_reg);
        end
        if (load_out)
        begin
            status_reg     <= bad_pct;
            low_level_reg  <= bad_pct ? '0 : sat_level(v_lo);
            high_level_reg <= bad_pct ? '0 : sat_level(v_hi);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {high_level_reg, low_level_reg};
    assign m_tuser  = status_reg;

    // Sample path
    hpl_bin #(
        .BUCKETS (BUCKETS),
        .CW      (CW)
    ) u_bin (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .sample_db      (s_tdata),
        .range_floor    (range_floor_reg),
        .buckets_per_db (buckets_per_db_reg),
        .rd_en          (bin_rd_en),
        .rd_addr        (bin_rd_addr),
        .rd_data        (ram_rd_data),
        .wr_en          (bin_wr_en),
        .wr_addr        (bin_wr_addr),
        .wr_data        (bin_wr_data)
    );

    // Bucket sweep
    hpl_scan #(
        .BUCKETS (BUCKETS),
        .CW      (CW)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (scan_start),
        .rank_lo   (rank_lo_reg),
        .rank_hi   (rank_hi_reg),
        .rd_addr   (scan_rd_addr),
        .rd_data   (ram_rd_data),
        .wr_en     (scan_wr_en),
        .wr_addr   (scan_wr_addr),
        .wr_data   (scan_wr_data),
        .lo_bucket (lo_bucket),
        .hi_bucket (hi_bucket),
        .sts       (scan_sts)
    );

    // RAM port sharing: the two users never overlap
    assign ram_rd_addr = bin_rd_en ? bin_rd_addr : scan_rd_addr;
    assign ram_wr_en   = bin_wr_en | scan_wr_en;
    assign ram_wr_addr = scan_wr_en ? scan_wr_addr : bin_wr_addr;
    assign ram_wr_data = scan_wr_en ? scan_wr_data : bin_wr_data;

    // Bucket counts
    hpl_ram #(
        .WIDTH (CW),
        .DEPTH (BUCKETS)
    ) u_counts (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

FILE: hdl/hpl_checker.sv
// ----------------------------------------------------------------------------
// hpl_checker
// Port-level checks of the histogram percentile levels unit, bound to
// the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "histogram_percentile_levels_unit_macros.svh"

module hpl_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    // A stalled result holds
    `HPL_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `HPL_ASSERT_NEXT(a_out_stable, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))

    // A bad percentile pair reports zero levels
    `HPL_ASSERT_SAME(a_status_zero, clk, rst_n, m_tvalid && m_tuser, m_tdata == 32'd0)

    // Input only closes right after taking a sample (end of frame)
    `HPL_ASSERT_SAME(a_ready_drop, clk, rst_n, $fell(s_tready), $past(s_tvalid))

endmodule

bind histogram_percentile_levels_unit hpl_checker u_hpl_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
